[design/assert_macros.svh]
// Assertion helpers used by the checker file tmd_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds at every clock edge outside reset.
`define TMD_ASSERT(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");

// Check that a condition implies another one in the following cycle.
`define TMD_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

[design/tmd_pkg.sv]
package tmd_pkg;

  localparam int unsigned DedxW   = 24;
  localparam int unsigned EnergyW = 24;
  localparam int unsigned StepW   = 20;
  localparam int unsigned CoordW  = 16;
  localparam int unsigned HalfW   = 15;
  localparam int unsigned FracW   = 5;
  localparam int unsigned CountW  = 9;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_HALF_WIDTH  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_HALF_LENGTH = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_KEEP_NUM    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_KEEP_DEN    = 2'd3;

  localparam logic [HalfW-1:0] HALF_WIDTH_RST  = 15'd2600;
  localparam logic [HalfW-1:0] HALF_LENGTH_RST = 15'd2500;
  localparam logic [FracW-1:0] KEEP_NUM_RST    = 5'd3;
  localparam logic [FracW-1:0] KEEP_DEN_RST    = 5'd5;

  // divider operand selection
  localparam logic [1:0] SEL_HIT   = 2'd0;
  localparam logic [1:0] SEL_KEEP  = 2'd1;
  localparam logic [1:0] SEL_PLAIN = 2'd2;
  localparam logic [1:0] SEL_TRIM  = 2'd3;

  typedef struct packed {
    logic [EnergyW-1:0]       hit_energy_ev;
    logic [StepW-1:0]         hit_step_um;
    logic signed [CoordW-1:0] hit_x_mm;
    logic signed [CoordW-1:0] hit_y_mm;
    logic signed [CoordW-1:0] hit_z_mm;
    logic                     hit_secondary;
    logic                     last_hit;
  } hit_t;

  typedef struct packed {
    logic [CountW-1:0] hits_used;
    logic [DedxW-1:0]  plain_mean;
    logic [CountW-1:0] kept_count;
    logic [DedxW-1:0]  trimmed_mean;
    logic              plain_valid;
    logic              trimmed_valid;
    logic              hits_overflowed;
  } res_t;

  typedef struct packed {
    logic       take;
    logic       set_ovf;
    logic       div_start;
    logic [1:0] div_sel;
    logic       store;
    logic       latch_k;
    logic       latch_p;
    logic       load_vi;
    logic       scan;
    logic       acc;
    logic       latch_t;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic hit_ok;
    logic full;
    logic last;
    logic k_zero;
    logic div_done;
    logic scan_done;
    logic i_last;
    logic out_busy;
  } sts_t;

  // magnitude of a two's complement coordinate, one bit wider
  function automatic logic [CoordW:0] coord_mag(input logic signed [CoordW-1:0] c);
    logic [CoordW:0] e;
    e = {c[CoordW-1], c};
    return c[CoordW-1] ? (~e + 1'b1) : e;
  endfunction

endpackage

[design/tmd_channels.sv]
interface tmd_hit_if (input logic clk);
  import tmd_pkg::*;
  logic valid;
  logic ready;
  hit_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tmd_res_if (input logic clk);
  import tmd_pkg::*;
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[design/tmd_divider.sv]
module tmd_divider #(
  parameter int unsigned DW = 36,
  parameter int unsigned VW = 20
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);
  localparam int unsigned CntW = (DW > 1) ? $clog2(DW) : 1;
  localparam logic [CntW-1:0] LastStep = CntW'(DW - 1);

  logic [VW-1:0]   rem_r, rem_nxt;
  logic [DW-1:0]   quo_r, quo_nxt;
  logic [VW-1:0]   dv_r;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [VW:0]     sh;
  logic [VW:0]     diff;

  // one quotient bit per cycle, restoring
  always_comb begin
    sh       = {rem_r, quo_r[DW-1]};
    diff     = sh - {1'b0, dv_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[VW]) begin
        rem_nxt = diff[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[VW-1:0];
        quo_nxt = {quo_r[DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LastStep) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) dv_r <= divisor;
  end

  assign quotient = quo_r;
  assign done     = done_r;
endmodule

[design/tmd_datapath.sv]
module tmd_datapath #(
  parameter int unsigned MAX_HITS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tmd_pkg::cmd_t               cmd,
  output tmd_pkg::sts_t               sts,
  input  tmd_pkg::hit_t               in_data,
  input  logic                        cfg_we,
  input  logic [tmd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tmd_pkg::HalfW-1:0]   cfg_wdata,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tmd_pkg::res_t               out_data
);
  import tmd_pkg::*;

  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned AW = $clog2(MAX_HITS);
  localparam int unsigned SW = DedxW + CW;
  localparam int unsigned DW = (SW > 36) ? SW : 36;
  localparam int unsigned VW = (CW > StepW) ? CW : StepW;
  localparam logic [CW-1:0] Cap = CW'(MAX_HITS);

  logic [HalfW-1:0] half_w_r, half_l_r;
  logic [FracW-1:0] num_r, den_r;
  hit_t             hit_r;
  logic [CW-1:0]    cnt_r, k_r, idx_r, ja_r, jc_r, rank_r;
  logic             cmpv_r, ovf_r, out_valid_r;
  logic [SW-1:0]    sum_r, tsum_r;
  logic [DedxW-1:0] pmean_r, vi_r, rdata_r;
  res_t             res_r;
  logic [DedxW-1:0] mem [MAX_HITS];

  logic [FracW-1:0]    den_eff, num_eff;
  logic [CW+FracW-1:0] keep_prod;
  logic [DW-1:0]       dividend, quo;
  logic [VW-1:0]       divisor;
  logic                div_done;
  logic [DedxW-1:0]    dedx_sat;
  logic [AW-1:0]       rd_addr;
  logic                issue;
  logic [CW+8:0]       n_ext, k_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_w_r <= HALF_WIDTH_RST;
      half_l_r <= HALF_LENGTH_RST;
      num_r    <= KEEP_NUM_RST;
      den_r    <= KEEP_DEN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HALF_WIDTH:  half_w_r <= cfg_wdata;
        REG_HALF_LENGTH: half_l_r <= cfg_wdata;
        REG_KEEP_NUM:    num_r    <= cfg_wdata[FracW-1:0];
        REG_KEEP_DEN:    den_r    <= cfg_wdata[FracW-1:0];
        default: ;
      endcase
    end
  end

  assign den_eff   = (den_r == '0) ? FracW'(1) : den_r;
  assign num_eff   = (num_r > den_eff) ? den_eff : num_r;
  assign keep_prod = cnt_r * num_eff;

  always_comb begin
    dividend = '0;
    divisor  = '0;
    case (cmd.div_sel)
      SEL_HIT: begin
        dividend = DW'({hit_r.hit_energy_ev, 11'b0}) + DW'({hit_r.hit_energy_ev, 9'b0});
        divisor  = VW'(hit_r.hit_step_um);
      end
      SEL_KEEP: begin
        dividend = DW'(keep_prod);
        divisor  = VW'(den_eff);
      end
      SEL_PLAIN: begin
        dividend = DW'(sum_r);
        divisor  = VW'(cnt_r);
      end
      default: begin
        dividend = DW'(tsum_r);
        divisor  = VW'(k_r);
      end
    endcase
  end

  tmd_divider #(.DW(DW), .VW(VW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(dividend), .divisor(divisor), .quotient(quo), .done(div_done)
  );

  assign dedx_sat = (quo[DW-1:DedxW] != '0) ? {DedxW{1'b1}} : quo[DedxW-1:0];

  // sample store
  assign issue   = (ja_r != cnt_r);
  assign rd_addr = cmd.scan ? ja_r[AW-1:0] : idx_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.store) mem[cnt_r[AW-1:0]] <= dedx_sat;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      sum_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cmpv_r      <= 1'b0;
    end else begin
      if (cmd.set_ovf) ovf_r <= 1'b1;
      if (cmd.store) begin
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_r + SW'(dedx_sat);
      end
      if (cmd.load_vi) cmpv_r <= 1'b0;
      else if (cmd.scan) cmpv_r <= issue;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
        cnt_r       <= '0;
        sum_r       <= '0;
        ovf_r       <= 1'b0;
      end
    end
  end

  assign n_ext = {9'b0, cnt_r};
  assign k_ext = {9'b0, k_r};

  always_ff @(posedge clk) begin
    if (cmd.take) hit_r <= in_data;
    if (cmd.latch_k) k_r <= quo[CW-1:0];
    if (cmd.latch_p) begin
      pmean_r <= (cnt_r == '0) ? '0 : quo[DedxW-1:0];
      idx_r   <= '0;
      tsum_r  <= '0;
    end
    if (cmd.load_vi) begin
      vi_r   <= rdata_r;
      ja_r   <= '0;
      rank_r <= '0;
    end
    if (cmd.scan) begin
      if (issue) ja_r <= ja_r + 1'b1;
      jc_r <= ja_r;
      if (cmpv_r && ((rdata_r < vi_r) || ((rdata_r == vi_r) && (jc_r < idx_r))))
        rank_r <= rank_r + 1'b1;
    end
    if (cmd.acc) begin
      if (rank_r < k_r) tsum_r <= tsum_r + SW'(vi_r);
      idx_r <= idx_r + 1'b1;
    end
    if (cmd.latch_t) begin
      res_r.hits_used       <= n_ext[8:0];
      res_r.plain_mean      <= pmean_r;
      res_r.kept_count      <= k_ext[8:0];
      res_r.trimmed_mean    <= (k_r == '0) ? '0 : quo[DedxW-1:0];
      res_r.plain_valid     <= (cnt_r != '0);
      res_r.trimmed_valid   <= (k_r != '0);
      res_r.hits_overflowed <= ovf_r;
    end
  end

  assign sts.hit_ok = !hit_r.hit_secondary && (hit_r.hit_energy_ev != '0)
                      && (hit_r.hit_step_um != '0)
                      && (coord_mag(hit_r.hit_x_mm) <= {2'b0, half_w_r})
                      && (coord_mag(hit_r.hit_y_mm) <= {2'b0, half_w_r})
                      && (coord_mag(hit_r.hit_z_mm) <= {2'b0, half_l_r});
  assign sts.full      = (cnt_r == Cap);
  assign sts.last      = hit_r.last_hit;
  assign sts.k_zero    = (k_r == '0);
  assign sts.div_done  = div_done;
  assign sts.scan_done = !issue && !cmpv_r;
  assign sts.i_last    = ((idx_r + 1'b1) == cnt_r);
  assign sts.out_busy  = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_data  = res_r;
endmodule

[design/tmd_ctrl.sv]
module tmd_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tmd_pkg::sts_t sts,
  output tmd_pkg::cmd_t cmd
);
  import tmd_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_JUDGE  = 4'd1;
  localparam logic [3:0] S_HDIV   = 4'd2;
  localparam logic [3:0] S_KSTART = 4'd3;
  localparam logic [3:0] S_KDIV   = 4'd4;
  localparam logic [3:0] S_PSTART = 4'd5;
  localparam logic [3:0] S_PDIV   = 4'd6;
  localparam logic [3:0] S_RDI    = 4'd7;
  localparam logic [3:0] S_LDI    = 4'd8;
  localparam logic [3:0] S_SCAN   = 4'd9;
  localparam logic [3:0] S_ACC    = 4'd10;
  localparam logic [3:0] S_TSTART = 4'd11;
  localparam logic [3:0] S_TDIV   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = S_JUDGE;
        end
      end
      S_JUDGE: begin
        if (sts.hit_ok && !sts.full) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = SEL_HIT;
          state_nxt     = S_HDIV;
        end else begin
          cmd.set_ovf = sts.hit_ok;
          state_nxt   = sts.last ? S_KSTART : S_IDLE;
        end
      end
      S_HDIV: begin
        cmd.div_sel = SEL_HIT;
        if (sts.div_done) begin
          cmd.store = 1'b1;
          state_nxt = sts.last ? S_KSTART : S_IDLE;
        end
      end
      S_KSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_KEEP;
        state_nxt     = S_KDIV;
      end
      S_KDIV: begin
        if (sts.div_done) begin
          cmd.latch_k = 1'b1;
          state_nxt   = S_PSTART;
        end
      end
      S_PSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_PLAIN;
        state_nxt     = S_PDIV;
      end
      S_PDIV: begin
        if (sts.div_done) begin
          cmd.latch_p = 1'b1;
          state_nxt   = sts.k_zero ? S_TSTART : S_RDI;
        end
      end
      S_RDI: state_nxt = S_LDI;
      S_LDI: begin
        cmd.load_vi = 1'b1;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = sts.i_last ? S_TSTART : S_RDI;
      end
      S_TSTART: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = SEL_TRIM;
        state_nxt     = S_TDIV;
      end
      S_TDIV: begin
        if (sts.div_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        // hold the quotient until the previous result has left
        if (!sts.out_busy) begin
          cmd.latch_t  = 1'b1;
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

[design/truncated_mean_dedx_estimator.sv]
// Truncated-mean dE/dx for one track. Hits arrive one request at a time on
// in_if; a rejected hit is judged and dropped, a kept hit also waits for the
// bit-serial divider that forms energy*2560/step one quotient bit per cycle
// over a 36-bit dividend. The last hit of a track then takes three more
// divisions (keep count, plain mean, trimmed mean) and, when the keep count
// is nonzero, a rank pass over the sample memory: each stored sample is
// read and compared with every other one through the single read port.
// The result waits in an output register for out_if.ready; the next
// track's hits are taken meanwhile, but a second result holds until the
// first has gone. Configuration writes take effect at once and belong only
// to idle periods.
module truncated_mean_dedx_estimator #(
  parameter int unsigned MAX_HITS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tmd_hit_if.sink                     in_if,
  tmd_res_if.source                   out_if,
  input  logic                        cfg_we,
  input  logic [tmd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tmd_pkg::HalfW-1:0]   cfg_wdata
);
  import tmd_pkg::*;

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  tmd_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_if.valid), .in_ready(in_if.ready),
    .sts(sts), .cmd(cmd)
  );

  // hold samples, sums and the result register
  tmd_datapath #(.MAX_HITS(MAX_HITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_data(in_if.data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
  );
endmodule

[design/tmd_checker.sv]
`include "assert_macros.svh"

module tmd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          out_valid,
  input logic          out_ready,
  input tmd_pkg::res_t out_data
);
  import tmd_pkg::*;

  `TMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
  `TMD_ASSERT(a_plain_flag, !out_valid || (out_data.plain_valid == (out_data.hits_used != '0)))
  `TMD_ASSERT(a_trim_flag, !out_valid || (out_data.trimmed_valid == (out_data.kept_count != '0)))
  `TMD_ASSERT(a_keep_le_used, !out_valid || (out_data.kept_count <= out_data.hits_used))
  `TMD_ASSERT(a_trim_le_plain, !out_valid || !out_data.trimmed_valid || (out_data.trimmed_mean <= out_data.plain_mean))
endmodule

bind truncated_mean_dedx_estimator tmd_checker u_tmd_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_if.valid), .out_ready(out_if.ready), .out_data(out_if.data)
);

[test/tmd_dedx_checker.sv]
module tmd_dedx_checker #(
  parameter int unsigned MAX_HITS = 256
) (
  input  logic                        clk,
  input  logic                        rst_n,
  tmd_hit_if                          hit_ch,
  tmd_res_if                          res_ch,
  input  logic                        cfg_we,
  input  logic [tmd_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tmd_pkg::HalfW-1:0]   cfg_wdata,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import tmd_pkg::*;

  logic [HalfW-1:0] box_xy, box_z;
  logic [FracW-1:0] frac_num, frac_den;
  logic [DedxW-1:0] samples [MAX_HITS];
  int unsigned      n_samples;
  longint unsigned  sample_sum;
  bit               samples_dropped;
  res_t             track_results [$];

  assign pending = track_results.size();

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  function automatic bit in_box(input logic signed [CoordW-1:0] c, input logic [HalfW-1:0] half);
    int mag;
    mag = (c < 0) ? -int'(c) : int'(c);
    return mag <= int'(half);
  endfunction

  // energy in eV over step in um, as 1/256 keV/cm, saturated
  function automatic logic [DedxW-1:0] dedx_of(input hit_t h);
    longint unsigned q;
    q = (longint'(h.hit_energy_ev) * 2560) / longint'(h.hit_step_um);
    return (q > 64'hFFFFFF) ? 24'hFFFFFF : q[DedxW-1:0];
  endfunction

  function automatic res_t track_summary();
    res_t r;
    int unsigned den, num, k;
    longint unsigned low_sum;
    logic [DedxW-1:0] sorted [$];
    den = (frac_den == 0) ? 1 : int'(frac_den);
    num = (int'(frac_num) > den) ? den : int'(frac_num);
    k = (n_samples * num) / den;
    for (int i = 0; i < n_samples; i++) sorted = {sorted, samples[i]};
    sorted.sort();
    low_sum = 0;
    for (int i = 0; i < k; i++) low_sum += sorted[i];
    r.hits_used       = n_samples[CountW-1:0];
    r.plain_mean      = n_samples ? DedxW'(sample_sum / n_samples) : '0;
    r.kept_count      = k[CountW-1:0];
    r.trimmed_mean    = k ? DedxW'(low_sum / k) : '0;
    r.plain_valid     = (n_samples != 0);
    r.trimmed_valid   = (k != 0);
    r.hits_overflowed = samples_dropped;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want, got;
    hit_t h;
    if (!rst_n) begin
      box_xy = HALF_WIDTH_RST;
      box_z = HALF_LENGTH_RST;
      frac_num = KEEP_NUM_RST;
      frac_den = KEEP_DEN_RST;
      n_samples = 0;
      sample_sum = 0;
      samples_dropped = 0;
      track_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_WIDTH:  box_xy = cfg_wdata;
          REG_HALF_LENGTH: box_z = cfg_wdata;
          REG_KEEP_NUM:    frac_num = cfg_wdata[FracW-1:0];
          REG_KEEP_DEN:    frac_den = cfg_wdata[FracW-1:0];
          default: ;
        endcase
      end
      // compare before absorbing: a result never belongs to a hit of the same edge
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (track_results.size() == 0) begin
          report("unrequested result", got.hits_used, -1);
        end else begin
          want = track_results.pop_front();
          if (got.hits_used !== want.hits_used)
            report("hits_used", got.hits_used, want.hits_used);
          if (got.plain_mean !== want.plain_mean)
            report("plain_mean", got.plain_mean, want.plain_mean);
          if (got.kept_count !== want.kept_count)
            report("kept_count", got.kept_count, want.kept_count);
          if (got.trimmed_mean !== want.trimmed_mean)
            report("trimmed_mean", got.trimmed_mean, want.trimmed_mean);
          if (got.plain_valid !== want.plain_valid)
            report("plain_valid", got.plain_valid, want.plain_valid);
          if (got.trimmed_valid !== want.trimmed_valid)
            report("trimmed_valid", got.trimmed_valid, want.trimmed_valid);
          if (got.hits_overflowed !== want.hits_overflowed)
            report("hits_overflowed", got.hits_overflowed, want.hits_overflowed);
        end
      end
      if (hit_ch.valid && hit_ch.ready) begin
        h = hit_ch.data;
        if (!h.hit_secondary && h.hit_energy_ev != 0 && h.hit_step_um != 0 &&
            in_box(h.hit_x_mm, box_xy) && in_box(h.hit_y_mm, box_xy) &&
            in_box(h.hit_z_mm, box_z)) begin
          if (n_samples < MAX_HITS) begin
            samples[n_samples] = dedx_of(h);
            sample_sum += samples[n_samples];
            n_samples++;
          end else begin
            samples_dropped = 1;
          end
        end
        if (h.last_hit) begin
          track_results = {track_results, track_summary()};
          n_samples = 0;
          sample_sum = 0;
          samples_dropped = 0;
        end
      end
    end
  end
endmodule

[test/truncated_mean_dedx_estimator_tb.sv]
module truncated_mean_dedx_estimator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tmd_pkg::*;

  // a full track of 256 samples has the longest rank pass
  localparam int IdleLimit  = 250000;
  localparam int SettleWait = 60;
  localparam int ItemTarget = 1500;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [HalfW-1:0] cfg_wdata;
  int fail_count, pending;

  tmd_hit_if hit_ch (clk);
  tmd_res_if res_ch (clk);

  truncated_mean_dedx_estimator dut (
    .clk(clk), .rst_n(rst_n), .in_if(hit_ch), .out_if(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  tmd_dedx_checker checker_i (
    .clk(clk), .rst_n(rst_n), .hit_ch(hit_ch), .res_ch(res_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending(pending)
  );

  // box as currently programmed, so that hits can be aimed inside or outside it
  logic [HalfW-1:0] cur_xy, cur_z;
  int  items_sent;
  bit  burst;

  initial clk = 0;
  always #2 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 60));
  endfunction

  // result side: random stalls, with calm stretches of steady ready
  int stall_left, calm_left;
  always @(posedge clk) begin
    if (calm_left > 0) begin
      res_ch.ready <= 1'b1;
      calm_left--;
    end else if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 99) < 3) calm_left = int'($urandom_range(50, 300));
      else if ($urandom_range(0, 99) < 25) stall_left = gap_len() + 1;
    end
  end

  // watchdog: end the run if nothing moves for too long
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (hit_ch.valid && hit_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // present one request and hold it until taken; valid stays high afterwards
  task automatic send(input hit_t h);
    int gap;
    gap = burst ? 0 : gap_len();
    if (gap > 0) begin
      hit_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    hit_ch.valid <= 1'b1;
    hit_ch.data  <= h;
    @(posedge clk);
    while (!hit_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  // drop valid, drain every outstanding result, then let a stray hit finish
  task automatic settle();
    hit_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
  endtask

  task automatic write_config(input logic [HalfW-1:0] xy, input logic [HalfW-1:0] z,
                              input logic [FracW-1:0] num, input logic [FracW-1:0] den);
    cfg_we <= 1'b1;
    cfg_index <= REG_HALF_WIDTH;
    cfg_wdata <= xy;
    @(posedge clk);
    cfg_index <= REG_HALF_LENGTH;
    cfg_wdata <= z;
    @(posedge clk);
    cfg_index <= REG_KEEP_NUM;
    cfg_wdata <= HalfW'(num);
    @(posedge clk);
    cfg_index <= REG_KEEP_DEN;
    cfg_wdata <= HalfW'(den);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_xy = xy;
    cur_z = z;
  endtask

  function automatic logic [31:0] rand_bits(input int w);
    return $urandom & ((32'd1 << $urandom_range(1, w)) - 1);
  endfunction

  function automatic logic signed [CoordW-1:0] coord_in(input logic [HalfW-1:0] half);
    int c;
    c = (half == 0) ? 0 : ($urandom_range(0, 3) == 0 ? int'(half)
                                                     : int'($urandom_range(0, half)));
    return CoordW'($urandom_range(0, 1) ? -c : c);
  endfunction

  function automatic logic signed [CoordW-1:0] coord_out(input logic [HalfW-1:0] half);
    int c;
    if (half == 15'h7FFF) return -16'sd32768;
    c = int'($urandom_range(int'(half) + 1, 32767));
    return CoordW'($urandom_range(0, 1) ? -c : c);
  endfunction

  function automatic hit_t make_hit(input bit last, input bit noisy);
    hit_t h;
    h.hit_energy_ev = EnergyW'(rand_bits(EnergyW));
    h.hit_step_um   = StepW'(rand_bits(StepW));
    if (h.hit_energy_ev == 0) h.hit_energy_ev = 1;
    if (h.hit_step_um == 0) h.hit_step_um = 1;
    h.hit_x_mm = coord_in(cur_xy);
    h.hit_y_mm = coord_in(cur_xy);
    h.hit_z_mm = coord_in(cur_z);
    h.hit_secondary = 1'b0;
    h.last_hit = last;
    if (noisy) begin
      case ($urandom_range(0, 7))
        0: h.hit_secondary = 1'b1;
        1: h.hit_energy_ev = '0;
        2: h.hit_step_um = '0;
        3: h.hit_x_mm = coord_out(cur_xy);
        4: h.hit_y_mm = coord_out(cur_xy);
        5: h.hit_z_mm = coord_out(cur_z);
        6: h.hit_x_mm = -16'sd32768;
        default: begin
          h.hit_x_mm = CoordW'($urandom);
          h.hit_y_mm = CoordW'($urandom);
          h.hit_z_mm = CoordW'($urandom);
          h.hit_secondary = 1'($urandom_range(0, 1));
        end
      endcase
    end
    return h;
  endfunction

  task automatic run_track(input int len, input int noise_pct);
    burst = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++)
      send(make_hit(i == len - 1, $urandom_range(0, 99) < noise_pct));
  endtask

  function automatic hit_t fixed_hit(input logic [EnergyW-1:0] e, input logic [StepW-1:0] s,
                                     input int x, input int y, input int z,
                                     input bit sec, input bit last);
    hit_t h;
    h.hit_energy_ev = e;
    h.hit_step_um = s;
    h.hit_x_mm = CoordW'(x);
    h.hit_y_mm = CoordW'(y);
    h.hit_z_mm = CoordW'(z);
    h.hit_secondary = sec;
    h.last_hit = last;
    return h;
  endfunction

  initial begin
    int len, tracks;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    hit_ch.valid = 1'b0;
    hit_ch.data = '0;
    res_ch.ready = 1'b0;
    cur_xy = HALF_WIDTH_RST;
    cur_z = HALF_LENGTH_RST;
    items_sent = 0;
    burst = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: a lone saturating sample gives a zero keep count
    send(fixed_hit(24'hFFFFFF, 20'd1, 2600, -2600, 2500, 0, 1));
    // box edges, zero sample, every rejection reason
    send(fixed_hit(24'd1, 20'hFFFFF, -2600, 2600, -2500, 0, 0));
    send(fixed_hit(24'd5000, 20'd300, 2601, 0, 0, 0, 0));
    send(fixed_hit(24'd5000, 20'd300, 0, -2601, 0, 0, 0));
    send(fixed_hit(24'd5000, 20'd300, 0, 0, 2501, 0, 0));
    send(fixed_hit(24'd5000, 20'd300, -32768, 0, 0, 0, 0));
    send(fixed_hit(24'd5000, 20'd300, 0, 0, 0, 1, 0));
    send(fixed_hit(24'd0, 20'd300, 0, 0, 0, 0, 0));
    send(fixed_hit(24'd5000, 20'd0, 0, 0, 0, 0, 0));
    send(fixed_hit(24'd800000, 20'd7, 100, 200, -300, 0, 0));
    send(fixed_hit(24'd123456, 20'd999, -5, 5, 0, 0, 1));
    // empty track
    send(fixed_hit(24'd5000, 20'd300, 0, 0, 0, 1, 1));
    settle();

    // zero box, numerator clamped, zero denominator read as one
    write_config(15'd0, 15'd0, 5'd20, 5'd0);
    send(fixed_hit(24'd7000, 20'd11, 0, 0, 0, 0, 0));
    send(fixed_hit(24'd7000, 20'd11, 1, 0, 0, 0, 0));
    send(fixed_hit(24'd9000, 20'd3, 0, 0, -1, 0, 0));
    send(fixed_hit(24'd100, 20'd50, 0, 0, 0, 0, 1));
    settle();

    // widest box, full fraction, one track well past capacity
    write_config(15'h7FFF, 15'h7FFF, 5'd16, 5'd16);
    send(fixed_hit(24'd4000, 20'd40, 32767, -32767, 32767, 0, 0));
    run_track(280, 3);
    settle();

    tracks = 0;
    while (items_sent < ItemTarget) begin
      if (tracks % 25 == 24) begin
        settle();
        case ($urandom_range(0, 4))
          0: write_config(15'h7FFF, 15'h7FFF, 5'd1, 5'd16);
          1: write_config(HalfW'($urandom_range(0, 40)), HalfW'($urandom_range(0, 40)),
                          FracW'($urandom_range(0, 31)), FracW'($urandom_range(0, 31)));
          2: write_config(HALF_WIDTH_RST, HALF_LENGTH_RST, KEEP_NUM_RST, KEEP_DEN_RST);
          default: write_config(HalfW'($urandom_range(0, 32767)),
                                HalfW'($urandom_range(0, 32767)),
                                FracW'($urandom_range(1, 16)), FracW'($urandom_range(1, 16)));
        endcase
      end
      case ($urandom_range(0, 19))
        0:       len = int'($urandom_range(31, 60));
        1, 2, 3: len = int'($urandom_range(9, 30));
        default: len = int'($urandom_range(1, 8));
      endcase
      run_track(len, 20);
      tracks++;
    end

    hit_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleWait) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+design
design/tmd_pkg.sv
design/tmd_channels.sv
design/tmd_divider.sv
design/tmd_datapath.sv
design/tmd_ctrl.sv
design/truncated_mean_dedx_estimator.sv
design/tmd_checker.sv
test/tmd_dedx_checker.sv
test/truncated_mean_dedx_estimator_tb.sv
